FILE: sv/prs_pkg.sv
// Shared constants, types and helper functions of the paired-read overlap search.
package prs_pkg;

  localparam int unsigned MAX_LEN    = 256;
  localparam int unsigned ADDR_W     = $clog2(MAX_LEN);
  localparam int unsigned LEN_W      = $clog2(MAX_LEN + 1);
  localparam int unsigned BASE_W     = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned PREFIX_LEN = 50;

  // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for every x below 2^15.
  localparam int unsigned RECIP_100   = 5243;
  localparam int unsigned RECIP_SHIFT = 19;

  localparam logic [BASE_W-1:0] BASE_N = 3'd4;

  localparam logic [7:0] DIFF_LIMIT_RST   = 8'd5;
  localparam logic [8:0] MIN_OVERLAP_RST  = 9'd30;
  localparam logic [6:0] DIFF_PERCENT_RST = 7'd20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIFF_LIMIT   = 2'd0,
    CFG_MIN_OVERLAP  = 2'd1,
    CFG_DIFF_PERCENT = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_LIM,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_DONE
  } state_e;

  // Any code above N is stored as N.
  function automatic logic [BASE_W-1:0] norm_base(input logic [BASE_W-1:0] b);
    norm_base = (b <= BASE_N) ? b : BASE_N;
  endfunction

  // A<->T, C<->G, N stays N.
  function automatic logic [BASE_W-1:0] complement(input logic [BASE_W-1:0] b);
    complement = (b < BASE_N) ? (3'd3 - b) : BASE_N;
  endfunction

endpackage

FILE: sv/prs_in_if.sv
// Request channel carrying one base of each read per request.
interface prs_in_if;
  logic                       valid;
  logic                       ready;
  logic [prs_pkg::BASE_W-1:0] base_first;
  logic                       has_first;
  logic [prs_pkg::BASE_W-1:0] base_second;
  logic                       has_second;
  logic                       last_pair;

  modport source (output valid, base_first, has_first, base_second, has_second, last_pair,
                  input ready);
  modport sink   (input valid, base_first, has_first, base_second, has_second, last_pair,
                  output ready);
endinterface

FILE: sv/prs_out_if.sv
// Result channel carrying the outcome of one overlap search.
interface prs_out_if;
  logic              valid;
  logic              ready;
  logic              overlapped;
  logic signed [9:0] shift;
  logic [8:0]        overlap_length;
  logic [8:0]        mismatches;

  modport source (output valid, overlapped, shift, overlap_length, mismatches, input ready);
  modport sink   (input valid, overlapped, shift, overlap_length, mismatches, output ready);
endinterface

FILE: sv/paired_read_overlap_search_unit.sv
// Top level of the paired-read overlap search unit.
// Requests arrive on in_req, one base of read 1 and one of read 2 per request,
// each marked present or absent; bases beyond 256 per read are dropped. A request
// with last_pair set closes the pair and starts the search; only such a request
// produces a result on out_res, exactly one. Requests are taken only while the
// unit is loading; during a search in_req.ready is low.
// The search tries forward shifts and then backward shifts, comparing read 1 with
// the reverse complement of read 2 one base per cycle through the two base stores.
// Each shift takes a loop test, a limit set-up, a scan over its overlap, a read
// drain and a decision; the change of direction adds a further loop test, and
// the result is then handed over to the output register. Scanning is bounded by
// the single read port of each store. A result sits in an output register;
// loading of the next pair carries on while it waits, and a finished search
// waits in its last state while the receiver stalls.
// Reset restores the registers to diff_limit 5, min_overlap 30, diff_percent 20
// and empties both reads; the stores themselves are not cleared, as only entries
// below the current lengths are ever read. Configuration writes belong to idle.
module paired_read_overlap_search_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  prs_in_if.sink                        in_req,
  prs_out_if.source                     out_res,
  input  logic                          cfg_we_i,
  input  logic [prs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [prs_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned AW = prs_pkg::ADDR_W;
  localparam int unsigned LW = prs_pkg::LEN_W;

  prs_pkg::state_e state_q, state_d;

  logic [7:0]    diff_limit_q;
  logic [8:0]    min_overlap_q;
  logic [6:0]    diff_percent_q;

  logic [LW-1:0] len1_q, len2_q, sh_q, ovl_q, idx_q, pipe_idx_q, diff_q, pre_q;
  logic          fwd_q, pipe_v_q;

  logic          out_valid_q, out_ovl_q, out_hit_q;
  logic [9:0]    out_shift_q;
  logic [8:0]    out_len_q, out_diff_q;

  logic          accept, out_free;
  logic          cont, ok, mm;
  logic [LW-1:0] ovl_new, diff_next;
  logic [LW+1:0] lim_span;
  logic [LW-1:0] a_idx, b_idx, b_addr;
  logic [8:0]    lim;
  logic [prs_pkg::BASE_W-1:0] rd1, rd2;

  // Control flags decoded from the state.
  logic ld_en, scan_en, last_issue;

  assign accept   = in_req.valid && in_req.ready;
  assign out_free = !out_valid_q || out_res.ready;

  // Search bound for the current direction, as a signed difference.
  assign lim_span = fwd_q ? ({2'b00, len1_q} - {2'b00, min_overlap_q})
                          : ({2'b00, len2_q} - {2'b00, min_overlap_q});
  assign cont     = $signed({2'b00, sh_q}) < $signed(lim_span);

  always_comb begin
    if (fwd_q) begin
      ovl_new = ((len1_q - sh_q) < len2_q) ? (len1_q - sh_q) : len2_q;
    end else begin
      ovl_new = (len1_q < (len2_q - sh_q)) ? len1_q : (len2_q - sh_q);
    end
  end

  // The shift offsets read 1 forward and read 2 backward. Read 2 is walked from
  // its end, which gives its reverse complement once each base is complemented.
  assign a_idx  = fwd_q ? (sh_q + idx_q) : idx_q;
  assign b_idx  = fwd_q ? idx_q : (sh_q + idx_q);
  assign b_addr = len2_q - LW'(1) - b_idx;

  prs_read_mem u_mem1 (
    .clk_i  (clk_i),
    .we_i   (accept && in_req.has_first && (len1_q < LW'(prs_pkg::MAX_LEN))),
    .addr_i (ld_en ? len1_q[AW-1:0] : a_idx[AW-1:0]),
    .wdata_i(prs_pkg::norm_base(in_req.base_first)),
    .rdata_o(rd1)
  );

  prs_read_mem u_mem2 (
    .clk_i  (clk_i),
    .we_i   (accept && in_req.has_second && (len2_q < LW'(prs_pkg::MAX_LEN))),
    .addr_i (ld_en ? len2_q[AW-1:0] : b_addr[AW-1:0]),
    .wdata_i(prs_pkg::norm_base(in_req.base_second)),
    .rdata_o(rd2)
  );

  prs_limit u_limit (
    .clk_i       (clk_i),
    .ovl_i       (ovl_q),
    .pct_i       (diff_percent_q),
    .diff_limit_i(diff_limit_q),
    .lim_o       (lim)
  );

  assign mm        = rd1 != prs_pkg::complement(rd2);
  assign diff_next = diff_q + LW'(mm);

  // A shift passes on its full count, or on its first fifty bases when longer.
  assign ok = (diff_q <= lim) ||
              ((ovl_q > LW'(prs_pkg::PREFIX_LEN)) && (pre_q <= lim));

  // Control flag decode.
  always_comb begin
    ld_en      = (state_q == prs_pkg::S_IDLE);
    scan_en    = (state_q == prs_pkg::S_SCAN);
    last_issue = scan_en && (idx_q == ovl_q - LW'(1));
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      prs_pkg::S_IDLE: begin
        if (accept && in_req.last_pair) state_d = prs_pkg::S_SHIFT;
      end
      prs_pkg::S_SHIFT: begin
        if (cont) state_d = prs_pkg::S_LIM;
        else if (!fwd_q) state_d = prs_pkg::S_DONE;
      end
      prs_pkg::S_LIM: begin
        state_d = (ovl_q == '0) ? prs_pkg::S_DRAIN : prs_pkg::S_SCAN;
      end
      prs_pkg::S_SCAN: begin
        if (last_issue) state_d = prs_pkg::S_DRAIN;
      end
      prs_pkg::S_DRAIN: state_d = prs_pkg::S_DECIDE;
      prs_pkg::S_DECIDE: state_d = ok ? prs_pkg::S_DONE : prs_pkg::S_SHIFT;
      prs_pkg::S_DONE: begin
        if (out_free) state_d = prs_pkg::S_IDLE;
      end
      default: state_d = prs_pkg::S_IDLE;
    endcase
  end

  assign in_req.ready = ld_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= prs_pkg::S_IDLE;
      diff_limit_q   <= prs_pkg::DIFF_LIMIT_RST;
      min_overlap_q  <= prs_pkg::MIN_OVERLAP_RST;
      diff_percent_q <= prs_pkg::DIFF_PERCENT_RST;
      len1_q         <= '0;
      len2_q         <= '0;
      fwd_q          <= 1'b1;
      pipe_v_q       <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      pipe_v_q <= scan_en;

      if (cfg_we_i) begin
        unique case (prs_pkg::cfg_idx_e'(cfg_idx_i))
          prs_pkg::CFG_DIFF_LIMIT:   diff_limit_q   <= cfg_data_i[7:0];
          prs_pkg::CFG_MIN_OVERLAP:  min_overlap_q  <= cfg_data_i;
          prs_pkg::CFG_DIFF_PERCENT: diff_percent_q <= cfg_data_i[6:0];
          default: ;
        endcase
      end

      if (accept && in_req.has_first && (len1_q < LW'(prs_pkg::MAX_LEN))) begin
        len1_q <= len1_q + LW'(1);
      end
      if (accept && in_req.has_second && (len2_q < LW'(prs_pkg::MAX_LEN))) begin
        len2_q <= len2_q + LW'(1);
      end

      if (state_q == prs_pkg::S_SHIFT && !cont && fwd_q) begin
        fwd_q <= 1'b0;
      end

      if (out_valid_q && out_res.ready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == prs_pkg::S_DONE && out_free) begin
        out_valid_q <= 1'b1;
        len1_q      <= '0;
        len2_q      <= '0;
        fwd_q       <= 1'b1;
      end
    end
  end

  // Search datapath and result payload.
  always_ff @(posedge clk_i) begin
    pipe_idx_q <= idx_q;
    unique case (state_q)
      prs_pkg::S_IDLE: begin
        sh_q      <= '0;
        out_ovl_q <= 1'b0;
      end
      prs_pkg::S_SHIFT: begin
        ovl_q <= ovl_new;
        if (!cont && fwd_q) sh_q <= '0;
      end
      prs_pkg::S_LIM: begin
        idx_q  <= '0;
        diff_q <= '0;
        pre_q  <= '0;
      end
      prs_pkg::S_DECIDE: begin
        if (ok) begin
          out_ovl_q <= 1'b1;
        end else begin
          sh_q <= sh_q + LW'(1);
        end
      end
      default: ;
    endcase

    if (scan_en) begin
      idx_q <= idx_q + LW'(1);
    end
    if (pipe_v_q) begin
      diff_q <= diff_next;
      if (pipe_idx_q == LW'(prs_pkg::PREFIX_LEN - 1)) pre_q <= diff_next;
    end

    // The found flag is copied with the rest of the payload, so that loading of
    // the next pair cannot change a result that is still waiting.
    if (state_q == prs_pkg::S_DONE && out_free) begin
      out_hit_q   <= out_ovl_q;
      out_shift_q <= out_ovl_q ? (fwd_q ? {1'b0, sh_q} : (10'd0 - {1'b0, sh_q})) : 10'd0;
      out_len_q   <= out_ovl_q ? ovl_q : 9'd0;
      out_diff_q  <= out_ovl_q ? diff_q : 9'd0;
    end
  end

  assign out_res.valid          = out_valid_q;
  assign out_res.overlapped     = out_hit_q;
  assign out_res.shift          = out_shift_q;
  assign out_res.overlap_length = out_len_q;
  assign out_res.mismatches     = out_diff_q;

`ifndef SYNTHESIS
  a_len1_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len1_q <= LW'(prs_pkg::MAX_LEN)) else $error("read 1 length beyond store depth");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == prs_pkg::S_DONE))
    else $error("result raised outside the completion state");

  a_scan_in_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_en |-> (idx_q < ovl_q)) else $error("scan index beyond overlap");
`endif

endmodule

FILE: sv/prs_read_mem.sv
// Synchronous single-port base store with registered read data.
module prs_read_mem (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [prs_pkg::ADDR_W-1:0] addr_i,
  input  logic [prs_pkg::BASE_W-1:0] wdata_i,
  output logic [prs_pkg::BASE_W-1:0] rdata_o
);

  logic [prs_pkg::BASE_W-1:0] mem_q [prs_pkg::MAX_LEN];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

FILE: sv/prs_limit.sv
// Two-stage mismatch limit: min(diff_limit, floor(overlap * percent / 100)).
module prs_limit (
  input  logic       clk_i,
  input  logic [8:0] ovl_i,
  input  logic [6:0] pct_i,
  input  logic [7:0] diff_limit_i,
  output logic [8:0] lim_o
);

  logic [15:0] prod_q;
  logic [29:0] scaled;
  logic [8:0]  quot;

  // The divide by 100 is a multiply by a scaled reciprocal.
  assign scaled = {14'd0, prod_q} * 30'(prs_pkg::RECIP_100);
  assign quot   = scaled[prs_pkg::RECIP_SHIFT +: 9];

  always_ff @(posedge clk_i) begin
    prod_q <= 16'(ovl_i) * 16'(pct_i);
    lim_o  <= (quot < {1'b0, diff_limit_i}) ? quot : {1'b0, diff_limit_i};
  end

endmodule
